// File: design/hdu_pkg.sv
`default_nettype none
package hdu_pkg;

    localparam int unsigned TICK_W = 9;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 9;
    localparam int unsigned BITS_PER_BYTE = 8;

    localparam logic [TICK_W-1:0] BIT_TICKS_RST = 9'd104;
    localparam logic [TICK_W-1:0] FIRST_TICKS_RST = 9'd156;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SAMPLE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_RX      = 2'd1,
        MODE_TX      = 2'd2,
        MODE_TX_STOP = 2'd3
    } t_mode;

    typedef struct packed {
        logic       rx_line;
        logic       send_valid;
        logic [7:0] send_byte;
        logic       take_byte;
    } t_in_beat;

    typedef struct packed {
        logic       tx_line;
        logic       send_accepted;
        logic       tx_busy;
        logic       rx_busy;
        logic       byte_ready;
        logic [7:0] rx_byte;
    } t_out_beat;

endpackage
`default_nettype wire

// File: design/half_duplex_uart.sv
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in  (t_in_beat, one tick)
// out       output     o_out_valid / i_out_ready  o_out (t_out_beat, one per tick)
// cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Each tick passes an input register and then the UART state update, which
// loads the result register.
// The rate is set by the single state update stage, which takes one tick
// per cycle when the result register is free or is being emptied.
// Reset is synchronous and active low; it sets the line high and resets the state, config and valid flags.
// A stalled result holds both stages; the next tick waits in the input register.
`default_nettype none
module half_duplex_uart (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire hdu_pkg::t_in_beat             i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output hdu_pkg::t_out_beat                 o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [hdu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [hdu_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hdu_pkg::*;

    logic              r_in_valid;
    t_in_beat          r_in;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic [TICK_W-1:0] r_bit_ticks;
    logic [TICK_W-1:0] r_first_ticks;
    logic              r_rx_enable;

    t_mode             r_mode, n_mode;
    logic [TICK_W-1:0] r_tick_count, n_tick_count;
    logic              r_first_interval, n_first_interval;
    logic [7:0]        r_tx_shift, n_tx_shift;
    logic [3:0]        r_tx_bits_sent, n_tx_bits_sent;
    logic [7:0]        r_rx_shift, n_rx_shift;
    logic [3:0]        r_rx_bits_taken, n_rx_bits_taken;
    logic [7:0]        r_held_byte, n_held_byte;
    logic              r_held_valid, n_held_valid;
    logic              r_line_out, n_line_out;
    logic              r_prev_rx, n_prev_rx;
    logic              n_accepted;

    logic              advance;
    logic              fire;
    logic              edge_seen;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] interval;
    logic              interval_done;

    assign advance     = !r_out_valid || i_out_ready;
    assign fire        = r_in_valid && advance;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign edge_seen     = r_prev_rx && !r_in.rx_line;
    assign tick_inc      = r_tick_count + TICK_W'(1);
    assign interval      = (r_mode == MODE_RX && r_first_interval) ? r_first_ticks
                                                                   : r_bit_ticks;
    assign interval_done = tick_inc >= interval;

    always_comb begin
        n_mode           = r_mode;
        n_tick_count     = r_tick_count;
        n_first_interval = r_first_interval;
        n_tx_shift       = r_tx_shift;
        n_tx_bits_sent   = r_tx_bits_sent;
        n_rx_shift       = r_rx_shift;
        n_rx_bits_taken  = r_rx_bits_taken;
        n_held_byte      = r_held_byte;
        n_held_valid     = r_held_valid && !r_in.take_byte;
        n_line_out       = r_line_out;
        n_prev_rx        = r_in.rx_line;
        n_accepted       = 1'b0;

        case (r_mode)
            MODE_IDLE: begin
                if (r_in.send_valid) begin
                    n_accepted     = 1'b1;
                    n_mode         = MODE_TX;
                    n_tx_shift     = r_in.send_byte;
                    n_tx_bits_sent = '0;
                    n_tick_count   = '0;
                    n_line_out     = 1'b0;
                end else if (r_rx_enable && edge_seen) begin
                    n_mode           = MODE_RX;
                    n_tick_count     = '0;
                    n_first_interval = 1'b1;
                    n_rx_bits_taken  = '0;
                    n_held_valid     = 1'b0;
                end
            end
            MODE_TX: begin
                n_tick_count = interval_done ? '0 : tick_inc;
                if (interval_done) begin
                    if (r_tx_bits_sent < 4'(BITS_PER_BYTE)) begin
                        n_line_out     = r_tx_shift[0];
                        n_tx_shift     = r_tx_shift >> 1;
                        n_tx_bits_sent = r_tx_bits_sent + 4'd1;
                    end else begin
                        n_line_out = 1'b1;
                        n_mode     = MODE_TX_STOP;
                    end
                end
            end
            MODE_TX_STOP: begin
                n_tick_count = interval_done ? '0 : tick_inc;
                if (interval_done) begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_RX: begin
                n_tick_count = interval_done ? '0 : tick_inc;
                if (interval_done) begin
                    n_first_interval = 1'b0;
                    if (r_rx_bits_taken < 4'(BITS_PER_BYTE)) begin
                        n_rx_bits_taken = r_rx_bits_taken + 4'd1;
                        n_rx_shift      = {r_in.rx_line, r_rx_shift[7:1]};
                    end else begin
                        n_held_byte  = r_rx_shift;
                        n_held_valid = 1'b1;
                        n_mode       = MODE_IDLE;
                    end
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ticks   <= BIT_TICKS_RST;
            r_first_ticks <= FIRST_TICKS_RST;
            r_rx_enable   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BIT_TICKS:          r_bit_ticks   <= i_cfg_data[TICK_W-1:0];
                CFG_FIRST_SAMPLE_TICKS: r_first_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_RX_ENABLE:          r_rx_enable   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.tx_line       <= n_line_out;
            r_out.send_accepted <= n_accepted;
            r_out.tx_busy       <= (n_mode == MODE_TX) || (n_mode == MODE_TX_STOP);
            r_out.rx_busy       <= n_mode == MODE_RX;
            r_out.byte_ready    <= n_held_valid;
            r_out.rx_byte       <= n_held_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= MODE_IDLE;
            r_tick_count     <= '0;
            r_first_interval <= 1'b0;
            r_tx_shift       <= '0;
            r_tx_bits_sent   <= '0;
            r_rx_shift       <= '0;
            r_rx_bits_taken  <= '0;
            r_held_byte      <= '0;
            r_held_valid     <= 1'b0;
            r_line_out       <= 1'b1;
            r_prev_rx        <= 1'b1;
        end else if (fire) begin
            r_mode           <= n_mode;
            r_tick_count     <= n_tick_count;
            r_first_interval <= n_first_interval;
            r_tx_shift       <= n_tx_shift;
            r_tx_bits_sent   <= n_tx_bits_sent;
            r_rx_shift       <= n_rx_shift;
            r_rx_bits_taken  <= n_rx_bits_taken;
            r_held_byte      <= n_held_byte;
            r_held_valid     <= n_held_valid;
            r_line_out       <= n_line_out;
            r_prev_rx        <= n_prev_rx;
        end
    end

endmodule
`default_nettype wire

// File: design/hdu_checker.sv
`default_nettype none
module hdu_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire hdu_pkg::t_in_beat              i_in,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire hdu_pkg::t_out_beat             o_out
);
    import hdu_pkg::*;

    // A waiting input beat stays valid and unchanged until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in))
        else $error("waiting input beat changed");

    // A stalled result beat stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result beat changed");

    // An accepted send starts with the start bit on the line.
    a_start_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.send_accepted |-> o_out.tx_busy && !o_out.tx_line)
        else $error("accepted send without start bit");

    // The half-duplex link never transmits and receives at once.
    a_half_duplex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.tx_busy && o_out.rx_busy))
        else $error("transmit and receive both busy");

    // A reception discards the pending byte, so none is pending while it runs.
    a_rx_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.rx_busy |-> !o_out.byte_ready)
        else $error("byte pending during reception");

endmodule

bind half_duplex_uart hdu_checker u_hdu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire

// File: test/tb_half_duplex_uart.sv
`timescale 1ns / 100ps
module tb_half_duplex_uart;
    import hdu_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {
        ROW_TICK,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_in_beat              beat;
        bit                    typed;
        t_out_beat             want;
    } t_row;

    typedef struct {
        logic [TICK_W-1:0] bit_ticks;
        logic [TICK_W-1:0] first_ticks;
        logic              rx_en;
        int                ticks;
        bit                idling;
    } t_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_beat              i_in = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_beat             o_out;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    half_duplex_uart u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the UART registers and state.
    logic [TICK_W-1:0] cfg_bit_ticks;
    logic [TICK_W-1:0] cfg_first_ticks;
    logic              cfg_rx_en;
    t_mode             mode;
    logic [TICK_W-1:0] tick_cnt;
    logic              first_interval;
    logic [7:0]        tx_shift;
    logic [3:0]        tx_sent;
    logic [7:0]        rx_shift;
    logic [3:0]        rx_taken;
    logic [7:0]        held_byte;
    logic              held_valid;
    logic              line_level;
    logic              prev_rx;

    t_out_beat uart_outputs_q[$];
    bit        rx_wave[$];
    int        mismatch_count = 0;
    bit        idle_on = 1'b0;
    int        stall_left = 0;

    function automatic bit period_elapsed(input logic [TICK_W-1:0] ticks);
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= ticks) begin
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_out_beat uart_tick(input t_in_beat b);
        t_out_beat r;
        logic      fall;
        logic      accepted;
        fall = prev_rx && !b.rx_line;
        accepted = 1'b0;
        if (b.take_byte) begin
            held_valid = 1'b0;
        end
        case (mode)
            MODE_IDLE: begin
                if (b.send_valid) begin
                    accepted = 1'b1;
                    mode = MODE_TX;
                    tx_shift = b.send_byte;
                    tx_sent = '0;
                    tick_cnt = '0;
                    line_level = 1'b0;
                end else if (cfg_rx_en && fall) begin
                    mode = MODE_RX;
                    tick_cnt = '0;
                    first_interval = 1'b1;
                    rx_taken = '0;
                    held_valid = 1'b0;
                end
            end
            MODE_TX: begin
                if (period_elapsed(cfg_bit_ticks)) begin
                    if (tx_sent < BITS_PER_BYTE) begin
                        line_level = tx_shift[0];
                        tx_shift = tx_shift >> 1;
                        tx_sent = tx_sent + 1'b1;
                    end else begin
                        line_level = 1'b1;
                        mode = MODE_TX_STOP;
                    end
                end
            end
            MODE_TX_STOP: begin
                if (period_elapsed(cfg_bit_ticks)) begin
                    mode = MODE_IDLE;
                end
            end
            default: begin
                if (period_elapsed(first_interval ? cfg_first_ticks : cfg_bit_ticks)) begin
                    first_interval = 1'b0;
                    if (rx_taken < BITS_PER_BYTE) begin
                        rx_taken = rx_taken + 1'b1;
                        rx_shift = {b.rx_line, rx_shift[7:1]};
                    end else begin
                        held_byte = rx_shift;
                        held_valid = 1'b1;
                        mode = MODE_IDLE;
                    end
                end
            end
        endcase
        prev_rx = b.rx_line;
        r.tx_line = line_level;
        r.send_accepted = accepted;
        r.tx_busy = (mode == MODE_TX) || (mode == MODE_TX_STOP);
        r.rx_busy = (mode == MODE_RX);
        r.byte_ready = held_valid;
        r.rx_byte = held_byte;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic drive_tick(input t_in_beat b, input bit typed, input t_out_beat want);
        t_out_beat predicted;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = uart_tick(b);
        uart_outputs_q.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (uart_outputs_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BIT_TICKS:          cfg_bit_ticks = data[TICK_W-1:0];
            CFG_FIRST_SAMPLE_TICKS: cfg_first_ticks = data[TICK_W-1:0];
            CFG_RX_ENABLE:          cfg_rx_en = data[0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 14);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : out_check
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (uart_outputs_q.size() == 0) begin
                $error("output beat %0h arrived with no tick pending", o_out);
                mismatch_count++;
            end else begin
                want = uart_outputs_q.pop_front();
                check_field("tx_line", want.tx_line, o_out.tx_line);
                check_field("send_accepted", want.send_accepted, o_out.send_accepted);
                check_field("tx_busy", want.tx_busy, o_out.tx_busy);
                check_field("rx_busy", want.rx_busy, o_out.rx_busy);
                check_field("byte_ready", want.byte_ready, o_out.byte_ready);
                check_field("rx_byte", want.rx_byte, o_out.rx_byte);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_row      rows[$];
        t_phase    phases[6];
        t_in_beat  b;
        t_out_beat none;
        int        per;
        int        kind;
        logic [7:0] d;

        none = '0;
        cfg_bit_ticks = BIT_TICKS_RST;
        cfg_first_ticks = FIRST_TICKS_RST;
        cfg_rx_en = 1'b1;
        mode = MODE_IDLE;
        tick_cnt = '0;
        first_interval = 1'b0;
        tx_shift = '0;
        tx_sent = '0;
        rx_shift = '0;
        rx_taken = '0;
        held_byte = '0;
        held_valid = 1'b0;
        line_level = 1'b1;
        prev_rx = 1'b1;

        // A send at the reset bit rate, a send refused while busy, then the
        // interval shortened to zero mid-bit so the frame finishes quickly.
        rows.push_back(t_row'{ROW_TICK, CFG_BIT_TICKS, '0, t_in_beat'{1'b1, 1'b0, 8'h00, 1'b0},
                              1'b1, t_out_beat'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}});
        rows.push_back(t_row'{ROW_TICK, CFG_BIT_TICKS, '0, t_in_beat'{1'b0, 1'b1, 8'hA5, 1'b0},
                              1'b1, t_out_beat'{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00}});
        rows.push_back(t_row'{ROW_TICK, CFG_BIT_TICKS, '0, t_in_beat'{1'b1, 1'b1, 8'h5A, 1'b0},
                              1'b1, t_out_beat'{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00}});
        rows.push_back(t_row'{ROW_CFG, CFG_BIT_TICKS, 9'd0, '0, 1'b0, none});
        for (int i = 0; i < 10; i++) begin
            rows.push_back(t_row'{ROW_TICK, CFG_BIT_TICKS, '0,
                                  t_in_beat'{i == 9, i == 4, 8'hFF, i == 0}, 1'b0, none});
        end
        // Reception of 0xFF with the first sample interval at zero.
        rows.push_back(t_row'{ROW_CFG, CFG_FIRST_SAMPLE_TICKS, 9'd0, '0, 1'b0, none});
        rows.push_back(t_row'{ROW_TICK, CFG_BIT_TICKS, '0, t_in_beat'{1'b0, 1'b0, 8'h00, 1'b0},
                              1'b0, none});
        for (int i = 0; i < 9; i++) begin
            rows.push_back(t_row'{ROW_TICK, CFG_BIT_TICKS, '0,
                                  t_in_beat'{1'b1, i == 1, 8'h00, i == 8}, 1'b0, none});
        end
        rows.push_back(t_row'{ROW_TICK, CFG_BIT_TICKS, '0, t_in_beat'{1'b1, 1'b0, 8'h00, 1'b1},
                              1'b1, t_out_beat'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF}});
        rows.push_back(t_row'{ROW_CFG, CFG_RX_ENABLE, 9'd0, '0, 1'b0, none});
        rows.push_back(t_row'{ROW_CFG, CFG_UNUSED, 9'h1FF, '0, 1'b0, none});
        rows.push_back(t_row'{ROW_TICK, CFG_BIT_TICKS, '0, t_in_beat'{1'b0, 1'b0, 8'h00, 1'b0},
                              1'b1, t_out_beat'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF}});

        phases[0] = t_phase'{9'd1,   9'd2,   1'b1, 120, 1'b1};
        phases[1] = t_phase'{9'd3,   9'd4,   1'b1, 100, 1'b0};
        phases[2] = t_phase'{9'd2,   9'd3,   1'b0, 40,  1'b1};
        phases[3] = t_phase'{9'd256, 9'd1,   1'b1, 60,  1'b1};
        phases[4] = t_phase'{9'd511, 9'd511, 1'b1, 40,  1'b1};
        phases[5] = t_phase'{9'd4,   9'd6,   1'b1, 120, 1'b0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                write_reg(rows[r].idx, rows[r].data);
            end else begin
                drive_tick(rows[r].beat, rows[r].typed, rows[r].want);
            end
        end

        foreach (phases[p]) begin
            write_reg(CFG_BIT_TICKS, phases[p].bit_ticks);
            write_reg(CFG_FIRST_SAMPLE_TICKS, phases[p].first_ticks);
            write_reg(CFG_RX_ENABLE, CFG_DATA_W'(phases[p].rx_en));
            idle_on = phases[p].idling;
            rx_wave.delete();
            repeat (phases[p].ticks) begin
                // The receive line mostly carries whole frames at about the
                // programmed bit rate, with broken frames and glitches mixed in.
                if (rx_wave.size() == 0) begin
                    per = (cfg_bit_ticks == 0) ? 1 : cfg_bit_ticks;
                    kind = $urandom_range(0, 9);
                    if (kind <= 6) begin
                        d = (kind == 0) ? 8'h00 : (kind == 1) ? 8'hFF : 8'($urandom);
                        if (per > 1 && $urandom_range(0, 3) == 0) begin
                            per = per + ($urandom_range(0, 1) ? 1 : -1);
                        end
                        repeat (per) rx_wave.push_back(1'b0);
                        for (int i = 0; i < BITS_PER_BYTE; i++) begin
                            repeat (per) rx_wave.push_back(d[i]);
                        end
                        repeat (per + $urandom_range(0, 3)) rx_wave.push_back(1'b1);
                    end else if (kind == 7) begin
                        repeat ($urandom_range(1, 4 * per)) begin
                            rx_wave.push_back(1'($urandom_range(0, 1)));
                        end
                        repeat (per) rx_wave.push_back(1'b1);
                    end else begin
                        repeat ($urandom_range(1, 6)) rx_wave.push_back(1'($urandom_range(0, 1)));
                    end
                end
                b.rx_line = rx_wave.pop_front();
                b.send_valid = ($urandom_range(0, 23) == 0);
                b.send_byte = 8'($urandom);
                b.take_byte = ($urandom_range(0, 3) == 0);
                drive_tick(b, 1'b0, none);
            end
        end

        i_in_valid <= 1'b0;
        while (uart_outputs_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
